// ===== hdl/tfb_pkg.sv =====
//------------------------------------------------------------------------------
// tfb_pkg
// Shared types and constants for the triangle fill bitmap block.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tfb_pkg;

	// Request codes
	localparam logic [1:0] REQ_DRAW  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// Register indexes on the APB port (word address)
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_INVERT = 2'd2;

	// 1/sqrt(3) in Q0.16
	localparam logic [15:0] INV_SQRT3_Q16 = 16'd37837;

	// Controller to datapath commands
	typedef struct packed {
		logic load;       // capture a new transaction
		logic fill_wr;    // write one fill byte, advance sweep counter
		logic fill_zero;  // fill with zero (power-up sweep)
		logic rd_issue;   // read byte at request address
		logic rd_cap;     // capture read result
		logic row_init;   // load first and end row
		logic row_off;    // compute row offset
		logic row_mul;    // half span multiply
		logic row_bnd;    // column bounds and clamping
		logic row_base;   // row base address
		logic row_next;   // advance to next row
		logic pix_rd;     // read byte under pixel
		logic pix_wr;     // write modified byte, advance column
		logic out_load;   // move result into output register
	} tfb_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic fill_last;
		logic row_end;
		logic span_empty;
		logic pix_last;
	} tfb_sts_t;

endpackage : tfb_pkg

`default_nettype wire

// ===== hdl/tfb_ctrl.sv =====
//------------------------------------------------------------------------------
// tfb_ctrl
// Sequencer: power-up clear, request dispatch, row and pixel walk, output.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfb_ctrl import tfb_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] req_type,
	output logic            out_valid,
	input  wire logic       out_stall,
	output tfb_cmd_t        cmd,
	input  wire tfb_sts_t   sts
);

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_FILL, S_RD, S_RDW, S_ROW0, S_CHK, S_MUL,
		S_BND, S_ADR, S_PRD, S_PWR, S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// Decode commands from state
	always_comb begin
		cmd = '0;
		cmd.load      = accept;
		cmd.fill_wr   = (state_q == S_INIT) || (state_q == S_FILL);
		cmd.fill_zero = (state_q == S_INIT);
		cmd.rd_issue  = (state_q == S_RD);
		cmd.rd_cap    = (state_q == S_RDW);
		cmd.row_init  = (state_q == S_ROW0);
		cmd.row_off   = (state_q == S_CHK);
		cmd.row_mul   = (state_q == S_MUL);
		cmd.row_bnd   = (state_q == S_BND);
		cmd.row_base  = (state_q == S_ADR);
		cmd.row_next  = ((state_q == S_ADR) && sts.span_empty) ||
		                ((state_q == S_PWR) && sts.pix_last);
		cmd.pix_rd    = (state_q == S_PRD);
		cmd.pix_wr    = (state_q == S_PWR);
		cmd.out_load  = (state_q == S_DONE) && out_free;
	end

	// Hold state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_INIT: if (sts.fill_last) state_q <= S_IDLE;
				S_IDLE: begin
					if (in_valid) begin
						case (req_type)
							REQ_DRAW:  state_q <= S_ROW0;
							REQ_READ:  state_q <= S_RD;
							REQ_CLEAR: state_q <= S_FILL;
							default:   state_q <= S_DONE;
						endcase
					end
				end
				S_FILL: if (sts.fill_last) state_q <= S_DONE;
				S_RD:   state_q <= S_RDW;
				S_RDW:  state_q <= S_DONE;
				S_ROW0: state_q <= S_CHK;
				S_CHK:  state_q <= sts.row_end ? S_DONE : S_MUL;
				S_MUL:  state_q <= S_BND;
				S_BND:  state_q <= S_ADR;
				S_ADR:  state_q <= sts.span_empty ? S_CHK : S_PRD;
				S_PRD:  state_q <= S_PWR;
				S_PWR:  state_q <= sts.pix_last ? S_CHK : S_PRD;
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule : tfb_ctrl

`default_nettype wire

// ===== hdl/tfb_dp.sv =====
//------------------------------------------------------------------------------
// tfb_dp
// Datapath: bitmap memory, row and span arithmetic, pixel read-modify-write.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfb_dp import tfb_pkg::*; #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512,
	parameter int FRAC_BITS  = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire tfb_cmd_t    cmd,
	output tfb_sts_t         sts,
	input  wire logic [9:0]  cfg_width,
	input  wire logic [9:0]  cfg_height,
	input  wire logic        cfg_invert,
	input  wire logic [15:0] center_row,
	input  wire logic [15:0] center_col,
	input  wire logic [15:0] half_height,
	input  wire logic        orientation,
	input  wire logic        pen,
	input  wire logic [14:0] byte_addr,
	output logic [7:0]       read_data,
	output logic             clipped
);

	localparam int STORE = ((MAX_WIDTH + 7) / 8) * MAX_HEIGHT;
	localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RHW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int RW    = 18;   // integer row index
	localparam int OW    = 20;   // signed row offset
	localparam int DW    = 37;   // signed half span product
	localparam int SW    = 38;   // signed column sums
	localparam int EW    = 22;   // rounded column bound

	logic [7:0] mem [STORE];
	logic [7:0] mem_q;

	// Captured transaction
	logic [15:0] r_q, c_q, h_q;
	logic        down_q, bit_q;
	logic [14:0] addr_q;
	logic [7:0]  fill_q;

	// Walk state
	logic [AW-1:0]         cnt_q;
	logic [RW-1:0]         i_q, re_q;
	logic signed [OW-1:0]  off_q;
	logic signed [DW-1:0]  dx_q;
	logic [CW-1:0]         j_q, hi_q;
	logic [RHW-1:0]        row_q;
	logic                  span_ok_q;
	logic [AW-1:0]         base_q;
	logic [7:0]            rd_w_q;
	logic                  clip_w_q;
	logic [7:0]            res_rd_q;
	logic                  res_clip_q;

	// Effective image size
	logic [9:0] eff_w, eff_h;
	logic [7:0] stride;
	logic [17:0] total;
	logic        in_range;

	always_comb begin
		if (cfg_width == 10'd0)                  eff_w = 10'd1;
		else if ({22'd0, cfg_width} > MAX_WIDTH) eff_w = 10'(MAX_WIDTH);
		else                                     eff_w = cfg_width;
		if (cfg_height == 10'd0)                   eff_h = 10'd1;
		else if ({22'd0, cfg_height} > MAX_HEIGHT) eff_h = 10'(MAX_HEIGHT);
		else                                       eff_h = cfg_height;
	end

	assign stride   = 8'(({1'b0, eff_w} + 11'd7) >> 3);
	assign total    = 18'(stride) * 18'(eff_h);
	assign in_range = ({3'd0, addr_q} < total) && ({17'd0, addr_q} < 32'(STORE));

	// Row bounds: round(r-h), round(r+h), negative taken as zero
	logic signed [17:0] rlo_v, rhi_v;
	logic [RW-1:0]      rs, re;

	assign rlo_v = $signed({2'b00, r_q}) - $signed({2'b00, h_q});
	assign rhi_v = $signed({2'b00, r_q}) + $signed({2'b00, h_q});
	assign rs = rlo_v[17] ? '0 : RW'({rlo_v, 1'b1} >> (FRAC_BITS + 1));
	assign re = rhi_v[17] ? '0 : RW'({rhi_v, 1'b1} >> (FRAC_BITS + 1));

	// Row offset from the apex side
	logic signed [OW-1:0] ip, rh_s, roff;
	assign ip   = $signed(OW'({2'b00, i_q} << FRAC_BITS));
	assign rh_s = $signed(OW'({2'b00, r_q}));
	assign roff = down_q ? (rh_s + $signed(OW'({2'b00, h_q})) - ip)
	                     : (ip - rh_s + $signed(OW'({2'b00, h_q})));

	// Column bounds
	logic signed [SW-1:0] cq, vs, ve;
	logic [EW-1:0]        s_b, e_b;
	logic [EW-1:0]        w_x;
	logic [CW-1:0]        lo_n, hi_n;
	logic                 span_ok, clip_n;
	logic [RHW-1:0]       row_n;

	assign cq  = $signed({6'd0, c_q, 16'd0});
	assign vs  = cq - SW'(dx_q);
	assign ve  = cq + SW'(dx_q);
	assign s_b = vs[SW-1] ? '0 : EW'({vs, 1'b1} >> (FRAC_BITS + 17));
	assign e_b = ve[SW-1] ? '0 : EW'({ve, 1'b1} >> (FRAC_BITS + 17));
	assign w_x = EW'(eff_w);
	assign span_ok = s_b < e_b;

	always_comb begin
		clip_n = 1'b0;
		if ({{(32-RW){1'b0}}, i_q} >= {22'd0, eff_h}) begin
			row_n  = RHW'(eff_h - 10'd1);
			clip_n = 1'b1;
		end else begin
			row_n = RHW'(i_q);
		end
		if (s_b >= w_x) begin
			lo_n   = CW'(eff_w - 10'd1);
			clip_n = 1'b1;
		end else begin
			lo_n = CW'(s_b);
		end
		if (e_b > w_x) begin
			hi_n   = CW'(eff_w - 10'd1);
			clip_n = 1'b1;
		end else begin
			hi_n = CW'(e_b - EW'(1));
		end
	end

	// Memory addressing
	logic [AW-1:0] pix_a, rd_a, wr_a;
	logic [7:0]    pmask, wr_d;
	logic          we, re_en;

	assign pix_a = base_q + AW'(j_q >> 3);
	assign pmask = 8'h80 >> j_q[2:0];
	assign rd_a  = cmd.rd_issue ? AW'(addr_q) : pix_a;
	assign re_en = cmd.rd_issue || cmd.pix_rd;
	assign we    = cmd.fill_wr || cmd.pix_wr;
	assign wr_a  = cmd.fill_wr ? cnt_q : pix_a;
	always_comb begin
		if (cmd.fill_wr)  wr_d = cmd.fill_zero ? 8'h00 : fill_q;
		else if (bit_q)   wr_d = mem_q | pmask;
		else              wr_d = mem_q & ~pmask;
	end

	// Bitmap store
	always_ff @(posedge clk) begin
		if (we)
			mem[wr_a] <= wr_d;
		if (re_en)
			mem_q <= mem[rd_a];
	end

	// Capture transaction and run arithmetic steps
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r_q    <= center_row;
			c_q    <= center_col;
			h_q    <= half_height;
			down_q <= orientation;
			bit_q  <= pen ^ cfg_invert;
			addr_q <= byte_addr;
			fill_q <= cfg_invert ? 8'hFF : 8'h00;
			rd_w_q <= 8'h00;
		end
		if (cmd.rd_cap)
			rd_w_q <= in_range ? mem_q : 8'h00;
		if (cmd.row_init) begin
			i_q  <= rs;
			re_q <= re;
		end
		if (cmd.row_off)
			off_q <= roff;
		if (cmd.row_mul)
			dx_q <= off_q * $signed({1'b0, INV_SQRT3_Q16});
		if (cmd.row_bnd) begin
			j_q       <= lo_n;
			hi_q      <= hi_n;
			row_q     <= row_n;
			span_ok_q <= span_ok;
		end
		if (cmd.row_base)
			base_q <= AW'(row_q) * AW'(stride);
		if (cmd.row_next)
			i_q <= i_q + RW'(1);
		if (cmd.pix_wr)
			j_q <= j_q + CW'(1);
		if (cmd.out_load) begin
			res_rd_q   <= rd_w_q;
			res_clip_q <= clip_w_q;
		end
	end

	// Sweep counter and clip flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			clip_w_q <= 1'b0;
		end else begin
			if (cmd.fill_wr)
				cnt_q <= sts.fill_last ? '0 : cnt_q + AW'(1);
			if (cmd.load)
				clip_w_q <= 1'b0;
			else if (cmd.row_bnd && span_ok && clip_n)
				clip_w_q <= 1'b1;
		end
	end

	assign sts.fill_last  = (cnt_q == AW'(STORE - 1));
	assign sts.row_end    = (i_q >= re_q);
	assign sts.span_empty = !span_ok_q;
	assign sts.pix_last   = (j_q == hi_q);

	assign read_data = res_rd_q;
	assign clipped   = res_clip_q;

endmodule : tfb_dp

`default_nettype wire

// ===== hdl/triangle_fill_bitmap.sv =====
//------------------------------------------------------------------------------
// triangle_fill_bitmap
// 1-bpp bitmap with a filled equilateral triangle drawer, byte read and clear.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in      | to block  | in_valid/in_stall  | req_type, center_row/col, ...
//  out     | from block| out_valid/out_stall| read_data, clipped
//  apb     | to block  | psel/penable/pready| paddr, pwdata, prdata
//
// Draw: each triangle row steps through offset, multiply, bound and address
// states, then each pixel is read and written (one memory port does read then
// write for each pixel). Read: issue, capture, output. Clear: one store byte
// per cycle, ((MAX_WIDTH+7)/8)*MAX_HEIGHT bytes. After reset the store is
// swept to zero; in_stall stays high meanwhile, registers are writable.
// One transaction at a time; a new one is taken while the last result waits.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module triangle_fill_bitmap import tfb_pkg::*; #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512,
	parameter int FRAC_BITS  = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [15:0] center_row,
	input  wire logic [15:0] center_col,
	input  wire logic [15:0] half_height,
	input  wire logic        orientation,
	input  wire logic        pen,
	input  wire logic [14:0] byte_addr,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       read_data,
	output logic             clipped,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [9:0] width_q, height_q;
	logic       invert_q;
	tfb_cmd_t   cmd;
	tfb_sts_t   sts;

	assign pready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 10'd512;
			height_q <= 10'd512;
			invert_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_WIDTH:  width_q  <= pwdata[9:0];
				REG_HEIGHT: height_q <= pwdata[9:0];
				REG_INVERT: invert_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		case (paddr[3:2])
			REG_WIDTH:  prdata = {22'd0, width_q};
			REG_HEIGHT: prdata = {22'd0, height_q};
			REG_INVERT: prdata = {31'd0, invert_q};
			default:    prdata = 32'd0;
		endcase
	end

	tfb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	tfb_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_width   (width_q),
		.cfg_height  (height_q),
		.cfg_invert  (invert_q),
		.center_row  (center_row),
		.center_col  (center_col),
		.half_height (half_height),
		.orientation (orientation),
		.pen         (pen),
		.byte_addr   (byte_addr),
		.read_data   (read_data),
		.clipped     (clipped)
	);

endmodule : triangle_fill_bitmap

`default_nettype wire

// ===== hdl/tfb_checker.sv =====
//------------------------------------------------------------------------------
// tfb_checker
// Port-level checks for the triangle fill bitmap, bound to the top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfb_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] read_data,
	input wire logic       clipped,
	input wire logic       pready
);

	// Hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// Keep a stalled payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(read_data) && $stable(clipped))
		else $error("stalled result changed");

	// A result never carries both read data and a clip flag
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(clipped && (read_data != 8'd0)))
		else $error("read data and clip flag together");

	// A taken transaction stalls the input for at least the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice back to back");

	// Configuration port never waits
	assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule : tfb_checker

bind triangle_fill_bitmap tfb_checker u_tfb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.read_data (read_data),
	.clipped   (clipped),
	.pready    (pready)
);

`default_nettype wire

// ===== verif/testbench.sv =====
//------------------------------------------------------------------------------
// testbench
// Checks the triangle fill bitmap block: draws, byte reads and clears are
// driven with random idling on both channels, and every result is compared
// against an in-bench bitmap predictor across several register settings.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import tfb_pkg::*;

	localparam int MW = 512;
	localparam int MH = 512;
	localparam int FB = 4;
	localparam int STORE = ((MW + 7) / 8) * MH;

	typedef struct {
		logic [1:0]  kind;
		logic [15:0] row_q;
		logic [15:0] col_q;
		logic [15:0] hh_q;
		logic        dn;
		logic        ink;
		logic [14:0] addr;
	} req_t;

	typedef struct {
		logic [7:0] data;
		logic       clip;
	} res_t;

	// directed row: request plus optional hand-typed result
	typedef struct {
		req_t req;
		bit   typed;
		res_t res;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] req_type = 0;
	logic [15:0] center_row = 0, center_col = 0, half_height = 0;
	logic orientation = 0, pen = 0;
	logic [14:0] byte_addr = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [7:0] read_data;
	logic clipped;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic pready;

	triangle_fill_bitmap dut (.*);

	always #10 clk = ~clk;

	// predictor state
	logic [7:0] pix_mem [STORE];
	logic [9:0] cfg_w = 10'd512, cfg_h = 10'd512;
	logic       cfg_inv = 0;
	res_t       pending [$];
	int         errors = 0;
	bit         quiet = 0;

	function automatic longint rnd_q(longint v, int sh);
		longint t;
		t = 2 * v + 1;
		if (t < 0) return 0;
		return t >>> (sh + 1);
	endfunction

	// compute the result of one transaction and update the bitmap copy
	function automatic res_t bitmap_apply(req_t q);
		res_t r;
		int w, h, stride, ri, lo, hi, a;
		longint rr, cc, hh, rs, re, off, s, e;
		logic b;
		r.data = 0;
		r.clip = 0;
		w = (cfg_w < 1) ? 1 : (cfg_w > MW ? MW : cfg_w);
		h = (cfg_h < 1) ? 1 : (cfg_h > MH ? MH : cfg_h);
		stride = (w + 7) / 8;
		if (q.kind == REQ_DRAW) begin
			rr = q.row_q; cc = q.col_q; hh = q.hh_q;
			b = q.ink ^ cfg_inv;
			rs = rnd_q(rr - hh, FB);
			re = rnd_q(rr + hh, FB);
			for (longint i = rs; i < re; i++) begin
				off = q.dn ? (rr + hh - (i << FB)) : ((i << FB) - rr + hh);
				s = rnd_q(cc * 65536 - off * INV_SQRT3_Q16, FB + 16);
				e = rnd_q(cc * 65536 + off * INV_SQRT3_Q16, FB + 16);
				if (s >= e) continue;
				if (i >= h) begin ri = h - 1; r.clip = 1; end else ri = int'(i);
				if (s >= w) begin lo = w - 1; r.clip = 1; end else lo = int'(s);
				if (e - 1 >= w) begin hi = w - 1; r.clip = 1; end else hi = int'(e - 1);
				for (int j = lo; j <= hi; j++) begin
					a = ri * stride + (j >> 3);
					if (a < STORE) pix_mem[a][7 - (j & 7)] = b;
				end
			end
		end else if (q.kind == REQ_READ) begin
			if (q.addr < stride * h) r.data = pix_mem[q.addr];
		end else if (q.kind == REQ_CLEAR) begin
			foreach (pix_mem[k]) pix_mem[k] = cfg_inv ? 8'hFF : 8'h00;
		end
		return r;
	endfunction

	// drive one transaction, waiting for acceptance; valid stays up until idling
	task automatic send_req(req_t q);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1;
		req_type <= q.kind;
		center_row <= q.row_q;
		center_col <= q.col_q;
		half_height <= q.hh_q;
		orientation <= q.dn;
		pen <= q.ink;
		byte_addr <= q.addr;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic apb_write(logic [1:0] idx, logic [31:0] val);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			REG_WIDTH:  cfg_w = val[9:0];
			REG_HEIGHT: cfg_h = val[9:0];
			default:    cfg_inv = val[0];
		endcase
		@(posedge clk);
	endtask

	// drop valid, wait for all results, then the block's tail latency
	task automatic drain();
		in_valid <= 0;
		while (pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic run_req(req_t q);
		pending.push_back(bitmap_apply(q));
		send_req(q);
	endtask

	function automatic req_t mk(logic [1:0] k, int r, int c, int h, bit d, bit p, int a);
		req_t q;
		q.kind = k; q.row_q = 16'(r); q.col_q = 16'(c); q.hh_q = 16'(h);
		q.dn = d; q.ink = p; q.addr = 15'(a);
		return q;
	endfunction

	// small triangle mostly inside the image, sometimes near or past edges
	function automatic req_t rand_req();
		req_t q;
		int p;
		p = $urandom_range(0, 99);
		q.row_q = 16'($urandom); q.col_q = 16'($urandom); q.hh_q = 16'($urandom);
		q.dn = 1'($urandom); q.ink = 1'($urandom); q.addr = 15'($urandom);
		if (p < 60) begin
			q.kind = REQ_DRAW;
			q.row_q = 16'($urandom_range(0, (cfg_h + 8) * 16));
			q.col_q = 16'($urandom_range(0, (cfg_w + 8) * 16));
			q.hh_q = 16'($urandom_range(0, 160));
		end else if (p < 62) begin
			q.kind = REQ_DRAW;
			q.hh_q = 16'($urandom_range(0, 1200));
		end else if (p < 93) begin
			q.kind = REQ_READ;
			if ($urandom_range(0, 3) != 0)
				q.addr = 15'($urandom_range(0, ((cfg_w + 7) / 8) * cfg_h + 2));
		end else if (p < 94) begin
			q.kind = REQ_CLEAR;
		end else begin
			q.kind = 2'd3;
		end
		return q;
	endfunction

	// output side: random stall bursts, compare each transaction
	initial begin
		res_t x;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (pending.size() == 0) begin
					$error("unexpected result data=%0h clip=%0b", read_data, clipped);
					errors++;
				end else begin
					x = pending.pop_front();
					if (read_data !== x.data) begin
						$error("read_data expected %0h actual %0h", x.data, read_data);
						errors++;
					end
					if (clipped !== x.clip) begin
						$error("clipped expected %0b actual %0b", x.clip, clipped);
						errors++;
					end
				end
			end
			if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_stall <= 0;
			end
		end
	end

	initial begin
		#400ms;
		$display("FAIL");
		$finish;
	end

	initial begin
		row_t dir [$];
		row_t rw;
		logic [31:0] widths [4];
		logic [31:0] heights [4];
		widths = '{32'd1, 32'd37, 32'd200, 32'd512};
		heights = '{32'd512, 32'd1, 32'd64, 32'd300};
		foreach (pix_mem[k]) pix_mem[k] = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;

		// read after reset, extremes, unknown code, clips, empties
		rw.typed = 1; rw.res = '{8'h00, 1'b0};
		rw.req = mk(REQ_READ, 0, 0, 0, 0, 0, 0); dir.push_back(rw);
		rw.req = mk(REQ_READ, 0, 0, 0, 0, 0, 32767); dir.push_back(rw);
		rw.req = mk(2'd3, 65535, 65535, 65535, 1, 1, 32767); dir.push_back(rw);
		rw.req = mk(REQ_DRAW, 100, 100, 0, 0, 1, 0); dir.push_back(rw);
		rw.req = mk(REQ_DRAW, 0, 0, 0, 1, 1, 0); dir.push_back(rw);
		rw.typed = 0;
		rw.req = mk(REQ_DRAW, 160, 160, 64, 0, 1, 0); dir.push_back(rw);
		rw.req = mk(REQ_DRAW, 400, 800, 96, 1, 1, 0); dir.push_back(rw);
		rw.req = mk(REQ_READ, 0, 0, 0, 0, 0, 10 * 64 + 10); dir.push_back(rw);
		rw.req = mk(REQ_DRAW, 8176, 8176, 48, 0, 1, 0); dir.push_back(rw);
		rw.req = mk(REQ_DRAW, 65535, 65535, 40, 1, 1, 0); dir.push_back(rw);
		rw.req = mk(REQ_DRAW, 0, 0, 100, 0, 0, 0); dir.push_back(rw);
		rw.req = mk(REQ_DRAW, 4000, 3000, 65535, 1, 1, 0); dir.push_back(rw);
		rw.req = mk(REQ_READ, 0, 0, 0, 0, 0, 32767); dir.push_back(rw);
		rw.req = mk(REQ_READ, 0, 0, 0, 0, 0, 1000); dir.push_back(rw);
		rw.req = mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0); dir.push_back(rw);
		rw.typed = 1;
		rw.req = mk(REQ_READ, 0, 0, 0, 0, 0, 1000); dir.push_back(rw);
		foreach (dir[i]) begin
			if (dir[i].typed) begin
				void'(bitmap_apply(dir[i].req));
				pending.push_back(dir[i].res);
				send_req(dir[i].req);
			end else begin
				run_req(dir[i].req);
			end
		end
		drain();

		// random phases over register settings, extremes included
		for (int ph = 0; ph < 6; ph++) begin
			apb_write(REG_WIDTH, ph < 4 ? widths[ph] : $urandom_range(1, 512));
			apb_write(REG_HEIGHT, ph < 4 ? heights[ph] : $urandom_range(1, 512));
			apb_write(REG_INVERT, 32'(ph & 1));
			if (ph == 5) quiet = 1;
			for (int n = 0; n < 165; n++) run_req(rand_req());
			drain();
		end
		apb_write(REG_WIDTH, 32'h3FF);
		apb_write(REG_HEIGHT, 32'h0);
		for (int n = 0; n < 20; n++) run_req(rand_req());
		drain();

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/tfb_pkg.sv
hdl/tfb_ctrl.sv
hdl/tfb_dp.sv
hdl/triangle_fill_bitmap.sv
hdl/tfb_checker.sv
verif/testbench.sv
